### hdl/tcov_pkg.sv
`default_nettype none

package tcov_pkg;

	// Fixed field widths of the item and result beats.
	localparam int TILE_IDX_W = 9;
	localparam int COLOR_W    = 24;
	localparam int MASK_W     = 64;
	localparam int DIM_W      = 13;
	localparam int CFG_IDX_W  = 1;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Values of the image size registers after reset.
	localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 13'd800;
	localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 13'd800;

	// Number of register stages from item to result.
	localparam int PIPE_DEPTH = 4;

	// Width of a tile origin coordinate (tile index times tile side, plus the pixel offset).
	function automatic int org_width(input int tile_side);
		return TILE_IDX_W + $clog2(tile_side);
	endfunction

	// Signed width that holds both a vertex coordinate and a pixel coordinate.
	function automatic int coord_width(input int coord_bits, input int tile_side);
		int ow;
		ow = org_width(tile_side);
		return (coord_bits > ow + 1) ? coord_bits : ow + 1;
	endfunction

	// Width of one cross product term.
	function automatic int prod_width(input int coord_bits, input int tile_side);
		return 2 * (coord_width(coord_bits, tile_side) + 1);
	endfunction

	// Width of a full edge function value at a pixel, with headroom for the steps.
	function automatic int edge_width(input int coord_bits, input int tile_side);
		return prod_width(coord_bits, tile_side) + 4;
	endfunction

endpackage

`default_nettype wire

### hdl/tcov_if.sv
`default_nettype none

// Triangle and tile item channel.
interface tcov_in_if #(parameter int COORD_BITS = 13) ();
	import tcov_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] v0_x;
	logic signed [COORD_BITS-1:0] v0_y;
	logic signed [COORD_BITS-1:0] v1_x;
	logic signed [COORD_BITS-1:0] v1_y;
	logic signed [COORD_BITS-1:0] v2_x;
	logic signed [COORD_BITS-1:0] v2_y;
	logic [TILE_IDX_W-1:0]        tile_col;
	logic [TILE_IDX_W-1:0]        tile_row;
	logic [COLOR_W-1:0]           fill_color;

	modport source (output valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y,
		tile_col, tile_row, fill_color, input ready);
	modport sink (input valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y,
		tile_col, tile_row, fill_color, output ready);
endinterface

// Coverage result channel.
interface tcov_out_if ();
	import tcov_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [MASK_W-1:0]     coverage_mask;
	logic [TILE_IDX_W-1:0] out_tile_col;
	logic [TILE_IDX_W-1:0] out_tile_row;
	logic [COLOR_W-1:0]    out_color;

	modport source (output valid, coverage_mask, out_tile_col, out_tile_row, out_color,
		input ready);
	modport sink (input valid, coverage_mask, out_tile_col, out_tile_row, out_color,
		output ready);
endinterface

// Register write channel.
interface tcov_cfg_if ();
	import tcov_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/tcov_setup.sv
`default_nettype none

module tcov_setup #(
	parameter int TILE_SIDE  = 8,
	parameter int COORD_BITS = 13,
	localparam int XW = tcov_pkg::coord_width(COORD_BITS, TILE_SIDE),
	localparam int DW = XW + 1,
	localparam int PW = tcov_pkg::prod_width(COORD_BITS, TILE_SIDE)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	tcov_in_if.sink                           item,
	input  logic [tcov_pkg::DIM_W-1:0]        image_width,
	input  logic [tcov_pkg::DIM_W-1:0]        image_height,
	output logic                              valid_s2,
	input  logic                              down_ready,
	output logic signed [DW-1:0]              dx_s2 [3],
	output logic signed [DW-1:0]              dy_s2 [3],
	output logic signed [PW-1:0]              pa_s2 [3],
	output logic signed [PW-1:0]              pb_s2 [3],
	output logic [TILE_SIDE-1:0]              row_ok_s2,
	output logic [TILE_SIDE-1:0]              col_ok_s2,
	output logic [tcov_pkg::TILE_IDX_W-1:0]   tile_col_s2,
	output logic [tcov_pkg::TILE_IDX_W-1:0]   tile_row_s2,
	output logic [tcov_pkg::COLOR_W-1:0]      color_s2
);
	import tcov_pkg::*;

	localparam int OW = org_width(TILE_SIDE);
	localparam int CW = (OW > DIM_W) ? OW : DIM_W;

	logic valid_s1;
	logic adv_s1;
	logic adv_s2;

	logic signed [XW-1:0] vx [3];
	logic signed [XW-1:0] vy [3];
	logic [OW-1:0]        ox_in;
	logic [OW-1:0]        oy_in;
	logic signed [XW-1:0] xlo_nx, xhi_nx, ylo_nx, yhi_nx;
	logic signed [DW-1:0] dx_nx [3];
	logic signed [DW-1:0] dy_nx [3];
	logic signed [DW-1:0] qx_nx [3];
	logic signed [DW-1:0] qy_nx [3];

	logic signed [DW-1:0]    dx_s1 [3];
	logic signed [DW-1:0]    dy_s1 [3];
	logic signed [DW-1:0]    qx_s1 [3];
	logic signed [DW-1:0]    qy_s1 [3];
	logic signed [XW-1:0]    xlo_s1, xhi_s1, ylo_s1, yhi_s1;
	logic [OW-1:0]           ox_s1;
	logic [OW-1:0]           oy_s1;
	logic [TILE_IDX_W-1:0]   tile_col_s1;
	logic [TILE_IDX_W-1:0]   tile_row_s1;
	logic [COLOR_W-1:0]      color_s1;

	logic [TILE_SIDE-1:0] row_ok_nx;
	logic [TILE_SIDE-1:0] col_ok_nx;

	// A stage moves on when it is empty or its successor moves on.
	assign adv_s2     = !valid_s2 || down_ready;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign item.ready = adv_s1;

	// Vertices widened to the common coordinate width, and the tile origin.
	assign vx[0] = XW'(item.v0_x);
	assign vy[0] = XW'(item.v0_y);
	assign vx[1] = XW'(item.v1_x);
	assign vy[1] = XW'(item.v1_y);
	assign vx[2] = XW'(item.v2_x);
	assign vy[2] = XW'(item.v2_y);
	assign ox_in = OW'(item.tile_col) * OW'(TILE_SIDE);
	assign oy_in = OW'(item.tile_row) * OW'(TILE_SIDE);

	// Bounding box of the three vertices, before clipping.
	always_comb begin
		xlo_nx = (vx[0] < vx[1]) ? vx[0] : vx[1];
		xlo_nx = (xlo_nx < vx[2]) ? xlo_nx : vx[2];
		xhi_nx = (vx[0] > vx[1]) ? vx[0] : vx[1];
		xhi_nx = (xhi_nx > vx[2]) ? xhi_nx : vx[2];
		ylo_nx = (vy[0] < vy[1]) ? vy[0] : vy[1];
		ylo_nx = (ylo_nx < vy[2]) ? ylo_nx : vy[2];
		yhi_nx = (vy[0] > vy[1]) ? vy[0] : vy[1];
		yhi_nx = (yhi_nx > vy[2]) ? yhi_nx : vy[2];
	end

	// Edge direction and tile origin relative to the edge start, for each edge.
	for (genvar k = 0; k < 3; k++) begin : g_edge
		localparam int B = (k + 1) % 3;
		assign dx_nx[k] = DW'(vx[B]) - DW'(vx[k]);
		assign dy_nx[k] = DW'(vy[B]) - DW'(vy[k]);
		assign qx_nx[k] = DW'($signed({1'b0, ox_in})) - DW'(vx[k]);
		assign qy_nx[k] = DW'($signed({1'b0, oy_in})) - DW'(vy[k]);
	end

	// Rows and columns of the tile that fall inside the clipped box.
	for (genvar r = 0; r < TILE_SIDE; r++) begin : g_lim
		logic [OW-1:0]        py;
		logic [OW-1:0]        px;
		logic signed [XW-1:0] pys;
		logic signed [XW-1:0] pxs;
		assign py  = oy_s1 + OW'(r);
		assign px  = ox_s1 + OW'(r);
		assign pys = XW'($signed({1'b0, py}));
		assign pxs = XW'($signed({1'b0, px}));
		assign row_ok_nx[r] = (pys >= ylo_s1) && (pys <= yhi_s1) &&
			(CW'(py) < CW'(image_height));
		assign col_ok_nx[r] = (pxs >= xlo_s1) && (pxs <= xhi_s1) &&
			(CW'(px) < CW'(image_width));
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= item.valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// First stage: differences and the box.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			dx_s1       <= dx_nx;
			dy_s1       <= dy_nx;
			qx_s1       <= qx_nx;
			qy_s1       <= qy_nx;
			xlo_s1      <= xlo_nx;
			xhi_s1      <= xhi_nx;
			ylo_s1      <= ylo_nx;
			yhi_s1      <= yhi_nx;
			ox_s1       <= ox_in;
			oy_s1       <= oy_in;
			tile_col_s1 <= item.tile_col;
			tile_row_s1 <= item.tile_row;
			color_s1    <= item.fill_color;
		end
	end

	// Second stage: the two cross product terms at the tile origin, and the row and column limits.
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			for (int k = 0; k < 3; k++) begin
				pa_s2[k] <= PW'(dx_s1[k]) * PW'(qy_s1[k]);
				pb_s2[k] <= PW'(dy_s1[k]) * PW'(qx_s1[k]);
			end
			dx_s2       <= dx_s1;
			dy_s2       <= dy_s1;
			row_ok_s2   <= row_ok_nx;
			col_ok_s2   <= col_ok_nx;
			tile_col_s2 <= tile_col_s1;
			tile_row_s2 <= tile_row_s1;
			color_s2    <= color_s1;
		end
	end

endmodule

`default_nettype wire

### hdl/tcov_eval.sv
`default_nettype none

module tcov_eval #(
	parameter int TILE_SIDE  = 8,
	parameter int COORD_BITS = 13,
	localparam int DW = tcov_pkg::coord_width(COORD_BITS, TILE_SIDE) + 1,
	localparam int PW = tcov_pkg::prod_width(COORD_BITS, TILE_SIDE)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid_s2,
	output logic                            up_ready,
	input  logic signed [DW-1:0]            dx_s2 [3],
	input  logic signed [DW-1:0]            dy_s2 [3],
	input  logic signed [PW-1:0]            pa_s2 [3],
	input  logic signed [PW-1:0]            pb_s2 [3],
	input  logic [TILE_SIDE-1:0]            row_ok_s2,
	input  logic [TILE_SIDE-1:0]            col_ok_s2,
	input  logic [tcov_pkg::TILE_IDX_W-1:0] tile_col_s2,
	input  logic [tcov_pkg::TILE_IDX_W-1:0] tile_row_s2,
	input  logic [tcov_pkg::COLOR_W-1:0]    color_s2,
	tcov_out_if.source                      result
);
	import tcov_pkg::*;

	localparam int EW = edge_width(COORD_BITS, TILE_SIDE);
	localparam int NPIX = TILE_SIDE * TILE_SIDE;

	logic valid_s3;
	logic valid_s4;
	logic adv_s3;
	logic adv_s4;

	logic signed [EW-1:0] erow_nx [3][TILE_SIDE];
	logic signed [EW-1:0] dyc_nx  [3][TILE_SIDE];
	logic signed [EW-1:0] erow_s3 [3][TILE_SIDE];
	logic signed [EW-1:0] dyc_s3  [3][TILE_SIDE];
	logic [TILE_SIDE-1:0]  row_ok_s3;
	logic [TILE_SIDE-1:0]  col_ok_s3;
	logic [TILE_IDX_W-1:0] tile_col_s3;
	logic [TILE_IDX_W-1:0] tile_row_s3;
	logic [COLOR_W-1:0]    color_s3;

	logic [MASK_W-1:0]     mask_nx;
	logic [MASK_W-1:0]     mask_s4;
	logic [TILE_IDX_W-1:0] tile_col_s4;
	logic [TILE_IDX_W-1:0] tile_row_s4;
	logic [COLOR_W-1:0]    color_s4;

	// The output register frees up as soon as the result beat is taken.
	assign adv_s4   = !valid_s4 || result.ready;
	assign adv_s3   = !valid_s3 || adv_s4;
	assign up_ready = adv_s3;

	// Edge value at the start of each tile row, and the step to each column.
	for (genvar k = 0; k < 3; k++) begin : g_edge
		for (genvar r = 0; r < TILE_SIDE; r++) begin : g_step
			assign erow_nx[k][r] = EW'(pa_s2[k]) - EW'(pb_s2[k]) +
				EW'(dx_s2[k]) * $signed(EW'(r));
			assign dyc_nx[k][r] = EW'(dy_s2[k]) * $signed(EW'(r));
		end
	end

	// Sign test of the triangle's edge functions at every pixel of the tile.
	for (genvar r = 0; r < TILE_SIDE; r++) begin : g_row
		for (genvar c = 0; c < TILE_SIDE; c++) begin : g_col
			logic signed [EW-1:0] e [3];
			logic [2:0]           neg;
			logic [2:0]           zero;
			for (genvar k = 0; k < 3; k++) begin : g_e
				assign e[k]    = erow_s3[k][r] - dyc_s3[k][c];
				assign neg[k]  = e[k][EW-1];
				assign zero[k] = (e[k] == '0);
			end
			assign mask_nx[r * TILE_SIDE + c] = row_ok_s3[r] && col_ok_s3[c] &&
				((~|neg) || (&(neg | zero)));
		end
	end

	// Bits beyond the tile stay clear.
	if (NPIX < MASK_W) begin : g_pad
		assign mask_nx[MASK_W-1:NPIX] = '0;
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s3)
				valid_s3 <= valid_s2;
			if (adv_s4)
				valid_s4 <= valid_s3;
		end
	end

	// Third stage: row start values and column steps.
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			erow_s3     <= erow_nx;
			dyc_s3      <= dyc_nx;
			row_ok_s3   <= row_ok_s2;
			col_ok_s3   <= col_ok_s2;
			tile_col_s3 <= tile_col_s2;
			tile_row_s3 <= tile_row_s2;
			color_s3    <= color_s2;
		end
	end

	// Fourth stage: the result register.
	always_ff @(posedge clk) begin
		if (adv_s4) begin
			mask_s4     <= mask_nx;
			tile_col_s4 <= tile_col_s3;
			tile_row_s4 <= tile_row_s3;
			color_s4    <= color_s3;
		end
	end

	assign result.valid         = valid_s4;
	assign result.coverage_mask = mask_s4;
	assign result.out_tile_col  = tile_col_s4;
	assign result.out_tile_row  = tile_row_s4;
	assign result.out_color     = color_s4;

endmodule

`default_nettype wire

### hdl/triangle_tile_coverage.sv
`default_nettype none

// Edge-function coverage of one square tile by one triangle. Each item beat carries three
// integer vertices, a tile index and a colour; each result beat carries the tile's coverage
// mask, bit row*TILE_SIDE+col, with the colour and tile index copied through. A pixel is
// covered when it lies in the vertex bounding box clipped to the image size registers and
// all of the triangle's edge functions share a sign, zero counting for either sign, so both
// windings fill and edge pixels are included. The block takes one item per clock cycle
// while the result channel is not stalled, through a four-stage pipeline (edge setup, origin
// products, row and column steps, per-pixel sign test). Back-pressure on the result channel
// stalls only the stages that are full, so bubbles close up. The image size registers reset
// to 800 by 800; the user must write them only while no item is in flight (not enforced).
module triangle_tile_coverage #(
	parameter int TILE_SIDE  = 8,
	parameter int COORD_BITS = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	tcov_cfg_if.sink    cfg,
	tcov_in_if.sink     item,
	tcov_out_if.source  result
);
	import tcov_pkg::*;

	localparam int DW = coord_width(COORD_BITS, TILE_SIDE) + 1;
	localparam int PW = prod_width(COORD_BITS, TILE_SIDE);
	localparam int FLIGHT_W = $clog2(PIPE_DEPTH + 1);

	logic [DIM_W-1:0] image_width_q;
	logic [DIM_W-1:0] image_height_q;

	logic                  valid_s2;
	logic                  eval_ready;
	logic signed [DW-1:0]  dx_s2 [3];
	logic signed [DW-1:0]  dy_s2 [3];
	logic signed [PW-1:0]  pa_s2 [3];
	logic signed [PW-1:0]  pb_s2 [3];
	logic [TILE_SIDE-1:0]  row_ok_s2;
	logic [TILE_SIDE-1:0]  col_ok_s2;
	logic [TILE_IDX_W-1:0] tile_col_s2;
	logic [TILE_IDX_W-1:0] tile_row_s2;
	logic [COLOR_W-1:0]    color_s2;

	logic [FLIGHT_W-1:0] in_flight_q;

	// Register writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg.data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	tcov_setup #(
		.TILE_SIDE  (TILE_SIDE),
		.COORD_BITS (COORD_BITS)
	) u_setup (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.valid_s2     (valid_s2),
		.down_ready   (eval_ready),
		.dx_s2        (dx_s2),
		.dy_s2        (dy_s2),
		.pa_s2        (pa_s2),
		.pb_s2        (pb_s2),
		.row_ok_s2    (row_ok_s2),
		.col_ok_s2    (col_ok_s2),
		.tile_col_s2  (tile_col_s2),
		.tile_row_s2  (tile_row_s2),
		.color_s2     (color_s2)
	);

	tcov_eval #(
		.TILE_SIDE  (TILE_SIDE),
		.COORD_BITS (COORD_BITS)
	) u_eval (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s2    (valid_s2),
		.up_ready    (eval_ready),
		.dx_s2       (dx_s2),
		.dy_s2       (dy_s2),
		.pa_s2       (pa_s2),
		.pb_s2       (pb_s2),
		.row_ok_s2   (row_ok_s2),
		.col_ok_s2   (col_ok_s2),
		.tile_col_s2 (tile_col_s2),
		.tile_row_s2 (tile_row_s2),
		.color_s2    (color_s2),
		.result      (result)
	);

	// Count of items taken in whose result beat has not yet gone out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q <= '0;
		end else begin
			in_flight_q <= in_flight_q + FLIGHT_W'(item.valid && item.ready) -
				FLIGHT_W'(result.valid && result.ready);
		end
	end

	// The pipeline never holds more items than it has stages.
	a_flight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q <= FLIGHT_W'(PIPE_DEPTH))
		else $error("more items in flight than pipeline stages");

	// A result is only offered for an item that was taken in.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (in_flight_q != '0))
		else $error("result offered with no item in flight");

	// Mask bits beyond the tile are always clear.
	a_mask_pad: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.coverage_mask >> (TILE_SIDE * TILE_SIDE)) == '0))
		else $error("coverage mask has bits set beyond the tile");

endmodule

`default_nettype wire

### dv/tb_triangle_tile_coverage.sv
`timescale 1ns / 1ps

module tb_triangle_tile_coverage;
	import tcov_pkg::*;

	localparam int TILE_SIDE      = 8;
	localparam int COORD_BITS     = 13;
	localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));
	localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
	localparam int PHASES         = 10;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = PIPE_DEPTH + 4;

	// One triangle and tile beat as the block receives it.
	typedef struct {
		logic signed [COORD_BITS-1:0] v0_x;
		logic signed [COORD_BITS-1:0] v0_y;
		logic signed [COORD_BITS-1:0] v1_x;
		logic signed [COORD_BITS-1:0] v1_y;
		logic signed [COORD_BITS-1:0] v2_x;
		logic signed [COORD_BITS-1:0] v2_y;
		logic [TILE_IDX_W-1:0]        tile_col;
		logic [TILE_IDX_W-1:0]        tile_row;
		logic [COLOR_W-1:0]           fill_color;
	} tile_job_t;

	// One coverage beat as the block should deliver it.
	typedef struct {
		logic [MASK_W-1:0]     mask;
		logic [TILE_IDX_W-1:0] col;
		logic [TILE_IDX_W-1:0] row;
		logic [COLOR_W-1:0]    color;
	} coverage_t;

	// A row of the hand-written stimulus, optionally with its mask worked out by hand.
	typedef struct {
		tile_job_t         job;
		bit                typed;
		logic [MASK_W-1:0] mask;
	} hand_row_t;

	logic clk = 1'b0;
	logic arst_n;

	tcov_in_if #(.COORD_BITS(COORD_BITS)) item_ch ();
	tcov_out_if                           res_ch ();
	tcov_cfg_if                           cfg_ch ();

	triangle_tile_coverage #(
		.TILE_SIDE (TILE_SIDE),
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.item  (item_ch),
		.result(res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Our copy of the image size registers, the pending coverage beats and the tallies.
	logic [DIM_W-1:0] img_w;
	logic [DIM_W-1:0] img_h;
	coverage_t        pending_cover[$];
	hand_row_t        hand_rows[$];
	int               mism_cnt = 0;
	int               stall_left = 0;
	int               idle_cycles = 0;
	bit               quiet = 1'b0;

	// Edge function of pixel p against the directed edge a to b.
	function automatic longint edge_val(input longint ax, input longint ay, input longint bx,
			input longint by, input longint px, input longint py);
		return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
	endfunction

	// Coverage mask of one tile for the given image size.
	function automatic logic [MASK_W-1:0] tile_cover(input tile_job_t j,
			input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		longint ax, ay, bx, by, cx, cy;
		longint xlo, xhi, ylo, yhi, wmax, hmax, px, py, e0, e1, e2;
		logic [MASK_W-1:0] m;
		ax = j.v0_x; ay = j.v0_y;
		bx = j.v1_x; by = j.v1_y;
		cx = j.v2_x; cy = j.v2_y;
		xlo = (ax < bx) ? ax : bx; xlo = (xlo < cx) ? xlo : cx;
		ylo = (ay < by) ? ay : by; ylo = (ylo < cy) ? ylo : cy;
		xhi = (ax > bx) ? ax : bx; xhi = (xhi > cx) ? xhi : cx;
		yhi = (ay > by) ? ay : by; yhi = (yhi > cy) ? yhi : cy;
		wmax = w; wmax = wmax - 1;
		hmax = h; hmax = hmax - 1;
		if (xlo < 0) xlo = 0;
		if (ylo < 0) ylo = 0;
		if (xhi > wmax) xhi = wmax;
		if (yhi > hmax) yhi = hmax;
		m = '0;
		for (int r = 0; r < TILE_SIDE; r++) begin
			py = longint'(j.tile_row) * TILE_SIDE + r;
			for (int c = 0; c < TILE_SIDE; c++) begin
				px = longint'(j.tile_col) * TILE_SIDE + c;
				if (py >= ylo && py <= yhi && px >= xlo && px <= xhi) begin
					e0 = edge_val(ax, ay, bx, by, px, py);
					e1 = edge_val(bx, by, cx, cy, px, py);
					e2 = edge_val(cx, cy, ax, ay, px, py);
					if ((e0 >= 0 && e1 >= 0 && e2 >= 0) || (e0 <= 0 && e1 <= 0 && e2 <= 0))
						m[r * TILE_SIDE + c] = 1'b1;
				end
			end
		end
		return m;
	endfunction

	// Clamp an integer into the vertex coordinate range.
	function automatic logic signed [COORD_BITS-1:0] clamp_coord(input int v);
		if (v < COORD_MIN)
			v = COORD_MIN;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v[COORD_BITS-1:0];
	endfunction

	// A coordinate scattered around c by up to s pixels either way.
	function automatic logic signed [COORD_BITS-1:0] near(input int c, input int s);
		return clamp_coord(c + int'($urandom_range(0, 2 * s)) - s);
	endfunction

	// Random triangle and tile. Most land around a tile inside the image so that the
	// edge tests see partial coverage; the rest are raw noise, flat, huge or mirrored to negative x.
	function automatic tile_job_t random_job(input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		tile_job_t j;
		int maxc, maxr, cx, cy, s, dx, dy, k, m, mode;
		int corners[3];
		corners = '{COORD_MIN, 0, COORD_MAX};
		mode = $urandom_range(0, 9);
		maxc = (w == 0) ? 0 : (int'(w) - 1) / TILE_SIDE;
		maxr = (h == 0) ? 0 : (int'(h) - 1) / TILE_SIDE;
		if (maxc > 511 || $urandom_range(0, 7) == 0) maxc = 511;
		if (maxr > 511 || $urandom_range(0, 7) == 0) maxr = 511;
		j.tile_col = TILE_IDX_W'($urandom_range(0, maxc));
		j.tile_row = TILE_IDX_W'($urandom_range(0, maxr));
		j.fill_color = COLOR_W'($urandom());
		cx = int'(j.tile_col) * TILE_SIDE + int'($urandom_range(0, TILE_SIDE - 1));
		cy = int'(j.tile_row) * TILE_SIDE + int'($urandom_range(0, TILE_SIDE - 1));
		case (mode)
			6: begin
				j.tile_col = TILE_IDX_W'($urandom());
				j.tile_row = TILE_IDX_W'($urandom());
				j.v0_x = COORD_BITS'($urandom()); j.v0_y = COORD_BITS'($urandom());
				j.v1_x = COORD_BITS'($urandom()); j.v1_y = COORD_BITS'($urandom());
				j.v2_x = COORD_BITS'($urandom()); j.v2_y = COORD_BITS'($urandom());
			end
			7: begin
				// Flat triangle: all three vertices on one line, sometimes one point.
				dx = $urandom_range(0, 1) ? int'($urandom_range(0, 6)) - 3 : 0;
				dy = $urandom_range(0, 1) ? int'($urandom_range(0, 6)) - 3 : 0;
				k = int'($urandom_range(0, 8)) - 4;
				m = int'($urandom_range(0, 8)) - 4;
				j.v0_x = clamp_coord(cx);          j.v0_y = clamp_coord(cy);
				j.v1_x = clamp_coord(cx + k * dx); j.v1_y = clamp_coord(cy + k * dy);
				j.v2_x = clamp_coord(cx + m * dx); j.v2_y = clamp_coord(cy + m * dy);
			end
			8: begin
				j.v0_x = COORD_BITS'(corners[$urandom_range(0, 2)]);
				j.v0_y = COORD_BITS'(corners[$urandom_range(0, 2)]);
				j.v1_x = COORD_BITS'(corners[$urandom_range(0, 2)]);
				j.v1_y = COORD_BITS'(corners[$urandom_range(0, 2)]);
				j.v2_x = COORD_BITS'(corners[$urandom_range(0, 2)]);
				j.v2_y = COORD_BITS'(corners[$urandom_range(0, 2)]);
			end
			default: begin
				case ($urandom_range(0, 3))
					0: s = 3;
					1: s = 12;
					2: s = 60;
					default: s = 2000;
				endcase
				if (mode == 9) begin
					cx = -cx;
					cy = $urandom_range(0, 1) ? -cy : cy;
				end
				j.v0_x = near(cx, s); j.v0_y = near(cy, s);
				j.v1_x = near(cx, s); j.v1_y = near(cy, s);
				j.v2_x = near(cx, s); j.v2_y = near(cy, s);
			end
		endcase
		return j;
	endfunction

	// Adds one hand-written row to the directed table.
	function automatic void add_row(input int x0, input int y0, input int x1, input int y1,
			input int x2, input int y2, input int col, input int row, input int color,
			input bit typed, input logic [MASK_W-1:0] mask);
		hand_row_t hr;
		hr.job.v0_x = COORD_BITS'(x0); hr.job.v0_y = COORD_BITS'(y0);
		hr.job.v1_x = COORD_BITS'(x1); hr.job.v1_y = COORD_BITS'(y1);
		hr.job.v2_x = COORD_BITS'(x2); hr.job.v2_y = COORD_BITS'(y2);
		hr.job.tile_col = TILE_IDX_W'(col);
		hr.job.tile_row = TILE_IDX_W'(row);
		hr.job.fill_color = COLOR_W'(color);
		hr.typed = typed;
		hr.mask = mask;
		hand_rows.push_back(hr);
	endfunction

	// Drive one item beat and hold it until taken; the expectation is queued on the
	// accepting edge. A random gap may follow unless the run is in its quiet part.
	task automatic send_job(input tile_job_t j, input bit typed, input logic [MASK_W-1:0] mask);
		coverage_t e;
		item_ch.valid      <= 1'b1;
		item_ch.v0_x       <= j.v0_x;
		item_ch.v0_y       <= j.v0_y;
		item_ch.v1_x       <= j.v1_x;
		item_ch.v1_y       <= j.v1_y;
		item_ch.v2_x       <= j.v2_x;
		item_ch.v2_y       <= j.v2_y;
		item_ch.tile_col   <= j.tile_col;
		item_ch.tile_row   <= j.tile_row;
		item_ch.fill_color <= j.fill_color;
		do @(posedge clk); while (!item_ch.ready);
		e.mask  = typed ? mask : tile_cover(j, img_w, img_h);
		e.col   = j.tile_col;
		e.row   = j.tile_row;
		e.color = j.fill_color;
		pending_cover.push_back(e);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every queued coverage beat has come back.
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (pending_cover.size() != 0)
			@(posedge clk);
	endtask

	// Write both image size registers, width first, then release the channel.
	task automatic write_dims(input int w, input int h);
		logic [DIM_W-1:0] vals[2];
		logic [CFG_IDX_W-1:0] idxs[2];
		vals = '{w[DIM_W-1:0], h[DIM_W-1:0]};
		idxs = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
		for (int i = 0; i < 2; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idxs[i];
			cfg_ch.data  <= vals[i];
			do @(posedge clk); while (!cfg_ch.ready);
			if (idxs[i] == REG_IMAGE_WIDTH)
				img_w = vals[i];
			else
				img_h = vals[i];
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Reports a field that differs; past the first ten only the count grows.
	function automatic void note_mismatch(input string field, input logic [MASK_W-1:0] exp_v,
			input logic [MASK_W-1:0] got_v);
		if (mism_cnt < 10)
			$display("mismatch on %s: expected %h, got %h", field, exp_v, got_v);
		mism_cnt++;
	endfunction

	// Result ready, stalled in random bursts of random length outside the quiet part.
	always @(posedge clk) begin
		logic rdy;
		if (stall_left > 0) begin
			stall_left--;
			rdy = 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 5) - 1;
			rdy = 1'b0;
		end else begin
			rdy = 1'b1;
		end
		res_ch.ready <= rdy;
	end

	// Compare each accepted coverage beat with the oldest expectation.
	always @(posedge clk) begin
		coverage_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_cover.size() == 0) begin
				if (mism_cnt < 10)
					$display("unexpected coverage beat: mask %h", res_ch.coverage_mask);
				mism_cnt++;
			end else begin
				e = pending_cover.pop_front();
				if (res_ch.coverage_mask !== e.mask)
					note_mismatch("coverage_mask", e.mask, res_ch.coverage_mask);
				if (res_ch.out_tile_col !== e.col)
					note_mismatch("out_tile_col", MASK_W'(e.col), MASK_W'(res_ch.out_tile_col));
				if (res_ch.out_tile_row !== e.row)
					note_mismatch("out_tile_row", MASK_W'(e.row), MASK_W'(res_ch.out_tile_row));
				if (res_ch.out_color !== e.color)
					note_mismatch("out_color", MASK_W'(e.color), MASK_W'(res_ch.out_color));
			end
		end
	end

	// Watchdog: too long without any beat on any channel ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Reset, the directed table, then random phases over a range of image sizes.
	initial begin
		int phase_w[PHASES];
		int phase_h[PHASES];
		int w, h;
		// A negative size stands for a random one.
		phase_w = '{800, 8191, 1, 0, 4096, 800, 37, -1, 4096, 2048};
		phase_h = '{800, 8191, 1, 800, 4096, 0, 21, -1, 1, 3000};
		arst_n              = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.v0_x        = '0;
		item_ch.v0_y        = '0;
		item_ch.v1_x        = '0;
		item_ch.v1_y        = '0;
		item_ch.v2_x        = '0;
		item_ch.v2_y        = '0;
		item_ch.tile_col    = '0;
		item_ch.tile_row    = '0;
		item_ch.fill_color  = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_IMAGE_WIDTH;
		cfg_ch.data         = '0;
		res_ch.ready        = 1'b0;
		img_w               = IMAGE_WIDTH_RST;
		img_h               = IMAGE_HEIGHT_RST;

		// Large triangle in both windings covers whole tiles; far tiles and boxes give none.
		add_row(0, 0, 4095, 0, 0, 4095, 0, 0, 0, 1'b1, '1);
		add_row(0, 0, 0, 4095, 4095, 0, 0, 0, 24'hFFFFFF, 1'b1, '1);
		add_row(0, 0, 4095, 0, 0, 4095, 99, 99, 24'h123456, 1'b1, '1);
		add_row(0, 0, 4095, 0, 0, 4095, 100, 0, 24'hFF0000, 1'b1, '0);
		add_row(0, 0, 4095, 0, 0, 4095, 511, 0, 24'h00FF00, 1'b1, '0);
		add_row(0, 0, 4095, 0, 0, 4095, 0, 511, 24'h0000FF, 1'b1, '0);
		add_row(-4096, -4096, -4096, -4096, -4096, -4096, 0, 0, 24'hAAAAAA, 1'b1, '0);
		add_row(4095, 4095, 4095, 4095, 4095, 4095, 511, 511, 24'h555555, 1'b1, '0);
		// Flat triangles: a single point, and horizontal, vertical and diagonal lines.
		add_row(3, 2, 3, 2, 3, 2, 0, 0, 24'h010203, 1'b1, 64'h0000_0000_0008_0000);
		add_row(0, 1, 7, 1, 3, 1, 0, 0, 24'h0A0B0C, 1'b1, 64'h0000_0000_0000_FF00);
		add_row(2, 0, 2, 7, 2, 4, 0, 0, 24'h0D0E0F, 1'b1, 64'h0404_0404_0404_0404);
		add_row(0, 0, 7, 7, 3, 3, 0, 0, 24'h102030, 1'b1, 64'h8040_2010_0804_0201);
		// Partial coverage, left to the predictor.
		add_row(0, 0, 7, 0, 0, 7, 0, 0, 24'h405060, 1'b0, '0);
		add_row(1, 0, 6, 7, 2, 5, 0, 0, 24'h708090, 1'b0, '0);
		add_row(-100, -100, 50, -100, -100, 50, 0, 0, 24'hA0B0C0, 1'b0, '0);
		add_row(9, 8, 15, 12, 10, 15, 1, 1, 24'hD0E0F0, 1'b0, '0);
		add_row(795, 790, 830, 799, 790, 820, 99, 98, 24'hFEDCBA, 1'b0, '0);
		add_row(-4096, 4095, 4095, -4096, 30, 30, 2, 3, 24'h13579B, 1'b0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (hand_rows[i])
			send_job(hand_rows[i].job, hand_rows[i].typed, hand_rows[i].mask);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain_results();
				w = (phase_w[ph] < 0) ? int'($urandom_range(1, 4096)) : phase_w[ph];
				h = (phase_h[ph] < 0) ? int'($urandom_range(1, 4096)) : phase_h[ph];
				write_dims(w, h);
			end
			// The last phase runs with no idling on either side.
			if (ph == PHASES - 1)
				quiet = 1'b1;
			repeat (ITEMS_PER_PHASE)
				send_job(random_job(img_w, img_h), 1'b0, '0);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mism_cnt == 0 && pending_cover.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
